// ----- src/pafm_pkg.sv -----
// ============================================================================
// pafm_pkg
// Shared types, constants and helpers for the pixel affine forward mapper.
// ============================================================================
package pafm_pkg;

    localparam int MAX_DIM   = 2048;
    localparam int MAX_SCALE = 4;

    // fixed field widths
    localparam int COORD_W = 11;
    localparam int DIM_W   = 12;
    localparam int CTR_W   = 13;
    localparam int TRIG_W  = 16;
    localparam int SCL_W   = 3;
    localparam int COLOR_W = 24;

    // datapath widths
    localparam int OFS_W  = CTR_W + 1;        // 2*src - center, signed
    localparam int PROD_W = OFS_W + TRIG_W;   // offset times trig, signed
    localparam int SUM_W  = PROD_W + 2;       // rotated sum plus center, signed
    localparam int BASE_W = 18;               // mapped base coordinate, signed
    localparam int FRAC_W = 14;               // Q2.14

    // block cells: one bit per (row, col), side is a power of two >= 4
    localparam int SIDE_BITS = (MAX_SCALE > 2) ? $clog2(MAX_SCALE) : 2;
    localparam int IDX_W     = 2 * SIDE_BITS;
    localparam int MASK_W    = 1 << IDX_W;

    // rotate pass cell order
    localparam logic [IDX_W-1:0] NB_CENTER = IDX_W'(0);
    localparam logic [IDX_W-1:0] NB_UP     = IDX_W'(1);
    localparam logic [IDX_W-1:0] NB_DOWN   = IDX_W'(2);
    localparam logic [IDX_W-1:0] NB_LEFT   = IDX_W'(3);
    localparam logic [IDX_W-1:0] NB_RIGHT  = IDX_W'(4);

    // pass selector
    localparam logic CMD_SCALE  = 1'b0;
    localparam logic CMD_ROTATE = 1'b1;

    // register map
    localparam int APB_AW = 5;
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CENTER_X2    = 3'd2;
    localparam logic [2:0] REG_CENTER_Y2    = 3'd3;
    localparam logic [2:0] REG_COS_Q14      = 3'd4;
    localparam logic [2:0] REG_SIN_Q14      = 3'd5;
    localparam logic [2:0] REG_SCALE_X      = 3'd6;
    localparam logic [2:0] REG_SCALE_Y      = 3'd7;

    typedef struct packed {
        logic [DIM_W-1:0]         frame_width;
        logic [DIM_W-1:0]         frame_height;
        logic [CTR_W-1:0]         center_x2;
        logic [CTR_W-1:0]         center_y2;
        logic signed [TRIG_W-1:0] cos_q14;
        logic signed [TRIG_W-1:0] sin_q14;
        logic [SCL_W-1:0]         scale_x;
        logic [SCL_W-1:0]         scale_y;
    } cfg_t;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [COLOR_W-1:0] color;
    } src_item_t;

    // a = ox*ma, b = oy*mb, c = ox*mc, d = oy*md
    typedef struct packed {
        logic                     cmd;
        logic [COLOR_W-1:0]       color;
        logic signed [PROD_W-1:0] pa;
        logic signed [PROD_W-1:0] pb;
        logic signed [PROD_W-1:0] pc;
        logic signed [PROD_W-1:0] pd;
    } prod_t;

    typedef struct packed {
        logic               cmd;
        logic [COLOR_W-1:0] color;
        logic [COORD_W-1:0] base_x;
        logic [COORD_W-1:0] base_y;
        logic [MASK_W-1:0]  mask;
    } cells_t;

    function automatic logic [SCL_W-1:0] clamp_scale(input logic [SCL_W-1:0] v);
        logic [SCL_W-1:0] r;
        r = v;
        if (v == '0)
            r = SCL_W'(1);
        else if (int'(v) > MAX_SCALE)
            r = SCL_W'(MAX_SCALE);
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (int'(v) > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

endpackage

// ----- src/pafm_cfg.sv -----
// ============================================================================
// pafm_cfg
// APB register file holding frame, center, trig and scale settings.
// ============================================================================
module pafm_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pafm_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output pafm_pkg::cfg_t               cfg
);

    pafm_pkg::cfg_t cfg_reg;
    pafm_pkg::cfg_t cfg_next;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[pafm_pkg::APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                pafm_pkg::REG_FRAME_WIDTH:
                    cfg_next.frame_width = pwdata[pafm_pkg::DIM_W-1:0];
                pafm_pkg::REG_FRAME_HEIGHT:
                    cfg_next.frame_height = pwdata[pafm_pkg::DIM_W-1:0];
                pafm_pkg::REG_CENTER_X2:
                    cfg_next.center_x2 = pwdata[pafm_pkg::CTR_W-1:0];
                pafm_pkg::REG_CENTER_Y2:
                    cfg_next.center_y2 = pwdata[pafm_pkg::CTR_W-1:0];
                pafm_pkg::REG_COS_Q14:
                    cfg_next.cos_q14 = pwdata[pafm_pkg::TRIG_W-1:0];
                pafm_pkg::REG_SIN_Q14:
                    cfg_next.sin_q14 = pwdata[pafm_pkg::TRIG_W-1:0];
                pafm_pkg::REG_SCALE_X:
                    cfg_next.scale_x = pwdata[pafm_pkg::SCL_W-1:0];
                pafm_pkg::REG_SCALE_Y:
                    cfg_next.scale_y = pwdata[pafm_pkg::SCL_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            pafm_pkg::REG_FRAME_WIDTH:  prdata = 32'(cfg_reg.frame_width);
            pafm_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg_reg.frame_height);
            pafm_pkg::REG_CENTER_X2:    prdata = 32'(cfg_reg.center_x2);
            pafm_pkg::REG_CENTER_Y2:    prdata = 32'(cfg_reg.center_y2);
            pafm_pkg::REG_COS_Q14:      prdata = 32'($unsigned(cfg_reg.cos_q14));
            pafm_pkg::REG_SIN_Q14:      prdata = 32'($unsigned(cfg_reg.sin_q14));
            pafm_pkg::REG_SCALE_X:      prdata = 32'(cfg_reg.scale_x);
            pafm_pkg::REG_SCALE_Y:      prdata = 32'(cfg_reg.scale_y);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= pafm_pkg::DIM_W'(pafm_pkg::MAX_DIM);
            cfg_reg.frame_height <= pafm_pkg::DIM_W'(pafm_pkg::MAX_DIM);
            cfg_reg.center_x2    <= '0;
            cfg_reg.center_y2    <= '0;
            cfg_reg.cos_q14      <= pafm_pkg::TRIG_W'(16384);
            cfg_reg.sin_q14      <= '0;
            cfg_reg.scale_x      <= pafm_pkg::SCL_W'(1);
            cfg_reg.scale_y      <= pafm_pkg::SCL_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/pafm_mult.sv -----
// ============================================================================
// pafm_mult
// Stages 1-2: offset from center, then the four signed products.
// ============================================================================
module pafm_mult
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pafm_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pafm_pkg::src_item_t   in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pafm_pkg::prod_t       out_item
);

    // stage 1
    logic                                 v1_reg;
    logic                                 v1_next;
    logic                                 s1_ready;
    logic                                 cmd1_reg;
    logic [pafm_pkg::COLOR_W-1:0]         color1_reg;
    logic signed [pafm_pkg::OFS_W-1:0]    ox_reg;
    logic signed [pafm_pkg::OFS_W-1:0]    oy_reg;
    logic signed [pafm_pkg::OFS_W-1:0]    ox_next;
    logic signed [pafm_pkg::OFS_W-1:0]    oy_next;

    // stage 2
    logic                                 v2_reg;
    logic                                 v2_next;
    logic                                 s2_ready;
    pafm_pkg::prod_t                      p2_reg;
    pafm_pkg::prod_t                      p2_next;
    logic signed [pafm_pkg::TRIG_W-1:0]   ma;
    logic signed [pafm_pkg::TRIG_W-1:0]   md;

    assign s2_ready = !v2_reg || out_ready;
    assign s1_ready = !v1_reg || s2_ready;
    assign in_ready = s1_ready;

    // 2*src - 2*center, exact in 14 signed bits
    assign ox_next = $signed({2'b00, in_item.src_x, 1'b0}) - $signed({1'b0, cfg.center_x2});
    assign oy_next = $signed({2'b00, in_item.src_y, 1'b0}) - $signed({1'b0, cfg.center_y2});

    // scale pass reuses the a and d products with the clamped scale factors
    always_comb
    begin
        if (cmd1_reg == pafm_pkg::CMD_ROTATE)
        begin
            ma = cfg.cos_q14;
            md = cfg.cos_q14;
        end
        else
        begin
            ma = $signed(pafm_pkg::TRIG_W'(pafm_pkg::clamp_scale(cfg.scale_x)));
            md = $signed(pafm_pkg::TRIG_W'(pafm_pkg::clamp_scale(cfg.scale_y)));
        end
        p2_next.cmd   = cmd1_reg;
        p2_next.color = color1_reg;
        p2_next.pa    = pafm_pkg::PROD_W'(ox_reg * ma);
        p2_next.pb    = pafm_pkg::PROD_W'(oy_reg * cfg.sin_q14);
        p2_next.pc    = pafm_pkg::PROD_W'(ox_reg * cfg.sin_q14);
        p2_next.pd    = pafm_pkg::PROD_W'(oy_reg * md);
    end

    assign v1_next = s1_ready ? in_valid : v1_reg;
    assign v2_next = s2_ready ? v1_reg : v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            cmd1_reg   <= in_item.cmd;
            color1_reg <= in_item.color;
            ox_reg     <= ox_next;
            oy_reg     <= oy_next;
        end
        if (s2_ready && v1_reg)
        begin
            p2_reg <= p2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = p2_reg;

endmodule

// ----- src/pafm_map.sv -----
// ============================================================================
// pafm_map
// Stages 3-4: add center and round, then frame check and cell mask.
// ============================================================================
module pafm_map
(
    input  logic              clk,
    input  logic              rst_n,
    input  pafm_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  pafm_pkg::prod_t   in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output pafm_pkg::cells_t  out_item
);

    localparam int SIDE = 1 << pafm_pkg::SIDE_BITS;

    // stage 3
    logic                                  v3_reg;
    logic                                  v3_next;
    logic                                  s3_ready;
    logic                                  cmd3_reg;
    logic [pafm_pkg::COLOR_W-1:0]          color3_reg;
    logic signed [pafm_pkg::BASE_W-1:0]    bx_reg;
    logic signed [pafm_pkg::BASE_W-1:0]    by_reg;
    logic signed [pafm_pkg::BASE_W-1:0]    bx_next;
    logic signed [pafm_pkg::BASE_W-1:0]    by_next;
    logic signed [pafm_pkg::SUM_W-1:0]     sum_x;
    logic signed [pafm_pkg::SUM_W-1:0]     sum_y;
    logic signed [pafm_pkg::SUM_W-1:0]     cx_term;
    logic signed [pafm_pkg::SUM_W-1:0]     cy_term;

    // stage 4
    logic                                  v4_reg;
    logic                                  v4_next;
    logic                                  s4_ready;
    pafm_pkg::cells_t                      c4_reg;
    pafm_pkg::cells_t                      c4_next;
    logic [pafm_pkg::DIM_W-1:0]            wc;
    logic [pafm_pkg::DIM_W-1:0]            hc;
    logic [pafm_pkg::SCL_W-1:0]            kx;
    logic [pafm_pkg::SCL_W-1:0]            ky;
    logic                                  base_ok;
    logic [pafm_pkg::DIM_W:0]              cell_x;
    logic [pafm_pkg::DIM_W:0]              cell_y;

    assign s4_ready = !v4_reg || out_ready;
    assign s3_ready = !v3_reg || s4_ready;
    assign in_ready = s3_ready;

    // rotate: (v + center*2^14 + 2^14) >>> 15; scale: (v + center + 1) >>> 1
    always_comb
    begin
        if (in_item.cmd == pafm_pkg::CMD_ROTATE)
        begin
            cx_term = $signed({{(pafm_pkg::SUM_W - pafm_pkg::CTR_W - pafm_pkg::FRAC_W){1'b0}},
                               cfg.center_x2, {pafm_pkg::FRAC_W{1'b0}}});
            cy_term = $signed({{(pafm_pkg::SUM_W - pafm_pkg::CTR_W - pafm_pkg::FRAC_W){1'b0}},
                               cfg.center_y2, {pafm_pkg::FRAC_W{1'b0}}});
            sum_x   = pafm_pkg::SUM_W'(in_item.pa) - pafm_pkg::SUM_W'(in_item.pb)
                    + cx_term + (pafm_pkg::SUM_W'(1) <<< pafm_pkg::FRAC_W);
            sum_y   = pafm_pkg::SUM_W'(in_item.pc) + pafm_pkg::SUM_W'(in_item.pd)
                    + cy_term + (pafm_pkg::SUM_W'(1) <<< pafm_pkg::FRAC_W);
            bx_next = pafm_pkg::BASE_W'(sum_x >>> (pafm_pkg::FRAC_W + 1));
            by_next = pafm_pkg::BASE_W'(sum_y >>> (pafm_pkg::FRAC_W + 1));
        end
        else
        begin
            cx_term = $signed({{(pafm_pkg::SUM_W - pafm_pkg::CTR_W){1'b0}}, cfg.center_x2});
            cy_term = $signed({{(pafm_pkg::SUM_W - pafm_pkg::CTR_W){1'b0}}, cfg.center_y2});
            sum_x   = pafm_pkg::SUM_W'(in_item.pa) + cx_term + pafm_pkg::SUM_W'(1);
            sum_y   = pafm_pkg::SUM_W'(in_item.pd) + cy_term + pafm_pkg::SUM_W'(1);
            bx_next = pafm_pkg::BASE_W'(sum_x >>> 1);
            by_next = pafm_pkg::BASE_W'(sum_y >>> 1);
        end
    end

    assign wc = pafm_pkg::clamp_dim(cfg.frame_width);
    assign hc = pafm_pkg::clamp_dim(cfg.frame_height);
    assign kx = pafm_pkg::clamp_scale(cfg.scale_x);
    assign ky = pafm_pkg::clamp_scale(cfg.scale_y);

    assign base_ok = !bx_reg[pafm_pkg::BASE_W-1] && !by_reg[pafm_pkg::BASE_W-1]
                  && (bx_reg < $signed({{(pafm_pkg::BASE_W - pafm_pkg::DIM_W){1'b0}}, wc}))
                  && (by_reg < $signed({{(pafm_pkg::BASE_W - pafm_pkg::DIM_W){1'b0}}, hc}));

    always_comb
    begin
        c4_next.cmd    = cmd3_reg;
        c4_next.color  = color3_reg;
        c4_next.base_x = bx_reg[pafm_pkg::COORD_W-1:0];
        c4_next.base_y = by_reg[pafm_pkg::COORD_W-1:0];
        c4_next.mask   = '0;
        cell_x         = '0;
        cell_y         = '0;
        if (cmd3_reg == pafm_pkg::CMD_ROTATE)
        begin
            c4_next.mask[pafm_pkg::NB_CENTER] = 1'b1;
            if (cfg.cos_q14 != '0 && cfg.sin_q14 != '0)
            begin
                cell_x = {{(pafm_pkg::DIM_W + 1 - pafm_pkg::COORD_W){1'b0}},
                          bx_reg[pafm_pkg::COORD_W-1:0]} + 1'b1;
                cell_y = {{(pafm_pkg::DIM_W + 1 - pafm_pkg::COORD_W){1'b0}},
                          by_reg[pafm_pkg::COORD_W-1:0]} + 1'b1;
                c4_next.mask[pafm_pkg::NB_UP]    = by_reg[pafm_pkg::COORD_W-1:0] != '0;
                c4_next.mask[pafm_pkg::NB_DOWN]  = cell_y < {1'b0, hc};
                c4_next.mask[pafm_pkg::NB_LEFT]  = bx_reg[pafm_pkg::COORD_W-1:0] != '0;
                c4_next.mask[pafm_pkg::NB_RIGHT] = cell_x < {1'b0, wc};
            end
        end
        else
        begin
            for (int i = 0; i < pafm_pkg::MASK_W; i++)
            begin
                c4_next.mask[i] = ((i % SIDE) < int'(kx)) && ((i / SIDE) < int'(ky))
                    && ((int'(bx_reg[pafm_pkg::COORD_W-1:0]) + (i % SIDE)) < int'(wc))
                    && ((int'(by_reg[pafm_pkg::COORD_W-1:0]) + (i / SIDE)) < int'(hc));
            end
        end
        if (!base_ok)
            c4_next.mask = '0;
    end

    assign v3_next = s3_ready ? in_valid : v3_reg;
    assign v4_next = s4_ready ? v3_reg : v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && in_valid)
        begin
            cmd3_reg   <= in_item.cmd;
            color3_reg <= in_item.color;
            bx_reg     <= bx_next;
            by_reg     <= by_next;
        end
        if (s4_ready && v3_reg)
        begin
            c4_reg <= c4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_item  = c4_reg;

endmodule

// ----- src/pafm_expand.sv -----
// ============================================================================
// pafm_expand
// Output stage: walks the cell mask, lowest cell first, one write per cycle while out_ready is high.
// ============================================================================
module pafm_expand
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pafm_pkg::cells_t               in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pafm_pkg::COORD_W-1:0]   dst_x,
    output logic [pafm_pkg::COORD_W-1:0]   dst_y,
    output logic [pafm_pkg::COLOR_W-1:0]   write_color,
    output logic                           last
);

    logic [pafm_pkg::MASK_W-1:0]   mask_reg;
    logic [pafm_pkg::MASK_W-1:0]   mask_next;
    logic                          cmd_reg;
    logic [pafm_pkg::COLOR_W-1:0]  color_reg;
    logic [pafm_pkg::COORD_W-1:0]  x_reg;
    logic [pafm_pkg::COORD_W-1:0]  y_reg;
    logic [pafm_pkg::MASK_W-1:0]   sel;
    logic [pafm_pkg::MASK_W-1:0]   rest;
    logic [pafm_pkg::IDX_W-1:0]    idx;

    // lowest pending cell
    assign sel  = mask_reg & (~mask_reg + 1'b1);
    assign rest = mask_reg & ~sel;

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < pafm_pkg::MASK_W; i++)
        begin
            if (sel[i])
                idx = pafm_pkg::IDX_W'(i);
        end
    end

    assign out_valid = mask_reg != '0;
    assign last      = rest == '0;
    assign in_ready  = (mask_reg == '0) || (out_ready && last);

    always_comb
    begin
        dst_x = x_reg;
        dst_y = y_reg;
        if (cmd_reg == pafm_pkg::CMD_ROTATE)
        begin
            case (idx)
                pafm_pkg::NB_CENTER: ;
                pafm_pkg::NB_UP:     dst_y = y_reg - 1'b1;
                pafm_pkg::NB_DOWN:   dst_y = y_reg + 1'b1;
                pafm_pkg::NB_LEFT:   dst_x = x_reg - 1'b1;
                pafm_pkg::NB_RIGHT:  dst_x = x_reg + 1'b1;
                default: ;
            endcase
        end
        else
        begin
            dst_x = x_reg + pafm_pkg::COORD_W'(idx[pafm_pkg::SIDE_BITS-1:0]);
            dst_y = y_reg + pafm_pkg::COORD_W'(idx[pafm_pkg::IDX_W-1:pafm_pkg::SIDE_BITS]);
        end
    end

    assign write_color = color_reg;

    always_comb
    begin
        if (in_ready)
            mask_next = in_valid ? in_item.mask : '0;
        else if (out_ready)
            mask_next = rest;
        else
            mask_next = mask_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else
            mask_reg <= mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg   <= in_item.cmd;
            color_reg <= in_item.color;
            x_reg     <= in_item.base_x;
            y_reg     <= in_item.base_y;
        end
    end

endmodule

// ----- src/pixel_affine_forward_mapper_top.sv -----
// ============================================================================
// pixel_affine_forward_mapper_top
// Forward maps source pixels about a region center (integer scale or
// Q2.14 rotation) and streams out the destination pixel writes.
// ============================================================================
//
//  channel   dir  handshake            payload
//  --------  ---  -------------------  -------------------------------------
//  s_*       in   s_tvalid / s_tready  tdata: src_x, src_y, pixel_color
//                                      tuser: cmd (0 scale, 1 rotate)
//  m_*       out  m_tvalid / m_tready  tdata: dst_x, dst_y, write_color
//                                      tlast: final write of the source pixel
//  apb       in   psel/penable/pready  8 registers at byte address 4*index
//
//  Pipeline: five register stages (offset, multiply, round, frame check, output).
//  The output stage issues one write per cycle while m_tready is high; a pixel
//  makes N writes (scale block up to 16, rotate up to 5), a dropped pixel none.
//  The input takes one pixel per cycle while the output keeps up.
//  Reset: valid bits and config registers are cleared/preset at once, no sweep.
//  Stalls: m_tready low freezes the output stage and backs up the pipeline
//  stage by stage; s_tready drops only when every stage is full.
// ============================================================================
module pixel_affine_forward_mapper_top
(
    input  logic                           clk,
    input  logic                           rst_n,

    // source pixel stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [47:0]                    s_tdata,   // src_x[10:0], src_y[21:11],
                                                      // pixel_color[45:22], zero pad
    input  logic                           s_tuser,   // cmd

    // destination write stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [47:0]                    m_tdata,   // dst_x[10:0], dst_y[21:11],
                                                      // write_color[45:22], zero pad
    output logic                           m_tlast,

    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pafm_pkg::APB_AW-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    pafm_pkg::cfg_t                  cfg;
    pafm_pkg::src_item_t             src_item;
    pafm_pkg::prod_t                 prod_item;
    pafm_pkg::cells_t                cells_item;
    logic                            prod_valid;
    logic                            prod_ready;
    logic                            cells_valid;
    logic                            cells_ready;
    logic [pafm_pkg::COORD_W-1:0]    dst_x;
    logic [pafm_pkg::COORD_W-1:0]    dst_y;
    logic [pafm_pkg::COLOR_W-1:0]    write_color;

    // unpack the source transfer
    assign src_item.cmd   = s_tuser;
    assign src_item.src_x = s_tdata[10:0];
    assign src_item.src_y = s_tdata[21:11];
    assign src_item.color = s_tdata[45:22];

    pafm_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // offsets and products
    pafm_mult u_mult
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (src_item),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_item  (prod_item)
    );

    // rounding, frame check, per-cell mask
    pafm_map u_map
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_item   (prod_item),
        .out_valid (cells_valid),
        .out_ready (cells_ready),
        .out_item  (cells_item)
    );

    // one write per cycle out of the mask while m_tready is high
    pafm_expand u_expand
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (cells_valid),
        .in_ready    (cells_ready),
        .in_item     (cells_item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .dst_x       (dst_x),
        .dst_y       (dst_y),
        .write_color (write_color),
        .last        (m_tlast)
    );

    assign m_tdata = {2'b00, write_color, dst_y, dst_x};

endmodule

// ----- src/pafm_checker.sv -----
// ============================================================================
// pafm_checker
// Port-level checks on the mapper's stream behavior, bound to the top level.
// ============================================================================
module pafm_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tlast
);

    // output side is empty while reset is held
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("m_tvalid high during reset");

    // with no write pending the whole pipeline drains, so input is open
    a_open_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with output idle");

    // a burst never gaps before its last write
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("write burst broke before tlast");

    // stalled write holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled write changed");

endmodule

bind pixel_affine_forward_mapper_top pafm_checker u_pafm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/sv/pixel_affine_forward_mapper_top_tb.sv -----
// ============================================================================
// pixel_affine_forward_mapper_top_tb
// Self-checking bench for the forward mapper: a directed plan of settings and
// source pixels (identity after reset, frame edges, empty and oversized
// frames, clamped scales, right angles, diagonal fill, wild trig values),
// then random settings with mostly near-center pixels. Every destination
// write is compared in order, field by field, with the predictor or a hand-typed value.
// ============================================================================
module pixel_affine_forward_mapper_top_tb;

    import pafm_pkg::*;

    // cycles between the last expected write and a register write or the end;
    // covers the five stages plus pixels that produce no write at all
    localparam int SETTLE_CYCLES  = 16;
    // long output stall, long enough to fill every stage and block the input
    localparam int HOLD_CYCLES    = 300;
    // cycles with no transfer on any port before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PIXELS_PER_SET = 13;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [47:0]         s_tdata;   // src_x[10:0], src_y[21:11], pixel_color[45:22]
    logic                s_tuser;   // cmd
    logic                m_tvalid;
    logic                m_tready;
    logic [47:0]         m_tdata;   // dst_x[10:0], dst_y[21:11], write_color[45:22]
    logic                m_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    pixel_affine_forward_mapper_top DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // Types and bench state
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [COORD_W-1:0] dst_x;
        logic [COORD_W-1:0] dst_y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pix_write_t;

    typedef enum bit {ROW_SETTING, ROW_PIXEL} row_kind_t;

    // one step of the directed plan; exp_n < 0 means "ask the predictor",
    // otherwise exp_n writes (0 or 1) at exp_x/exp_y are typed in by hand
    typedef struct {
        row_kind_t          kind;
        logic [2:0]         reg_idx;
        logic [31:0]        value;
        logic               cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        int                 exp_n;
        logic [COORD_W-1:0] exp_x;
        logic [COORD_W-1:0] exp_y;
    } plan_row_t;

    cfg_t        settings;          // bench copy of the register file
    pix_write_t  pending_writes[$]; // destination writes still owed by the DUT
    plan_row_t   plan[$];

    pix_write_t  got_write;
    pix_write_t  want_write;
    int          mismatches      = 0;
    int          writes_checked  = 0;
    int          idle_cycles     = 0;
    int          directed_pixels = 0;
    int          random_pixels   = 0;
    int          random_writes   = 0;
    int          settings_done   = 0;
    bit          quiet_tail      = 1'b0;  // no idling on either side
    bit          hold_request    = 1'b0;  // ask the receiver for one long stall

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint frame_limit(input logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : longint'(v);
    endfunction

    function automatic longint scale_factor(input logic [SCL_W-1:0] v);
        if (v == 0)
            return 1;
        return (v > MAX_SCALE) ? MAX_SCALE : longint'(v);
    endfunction

    function automatic bit on_frame(input longint x, input longint y);
        return x >= 0 && y >= 0 && x < frame_limit(settings.frame_width)
            && y < frame_limit(settings.frame_height);
    endfunction

    // queue one write unless that cell falls off the frame
    function automatic void queue_write(input longint x, input longint y,
                                        input logic [COLOR_W-1:0] color);
        pix_write_t w;
        if (on_frame(x, y))
        begin
            w.dst_x = x[COORD_W-1:0];
            w.dst_y = y[COORD_W-1:0];
            w.color = color;
            w.last  = 1'b0;
            pending_writes.push_back(w);
        end
    endfunction

    // forward map one source pixel; returns the number of writes queued
    function automatic int map_source_pixel(input logic cmd,
                                            input logic [COORD_W-1:0] sx,
                                            input logic [COORD_W-1:0] sy,
                                            input logic [COLOR_W-1:0] color);
        longint cx, cy, ox, oy, kx, ky, bx, by, c, s, vx, vy;
        int     first;
        first = pending_writes.size();
        cx = longint'(settings.center_x2);
        cy = longint'(settings.center_y2);
        // offsets at half-pixel resolution
        ox = 2 * longint'(sx) - cx;
        oy = 2 * longint'(sy) - cy;
        if (cmd == CMD_SCALE)
        begin
            kx = scale_factor(settings.scale_x);
            ky = scale_factor(settings.scale_y);
            bx = (ox * kx + cx + 1) >>> 1;
            by = (oy * ky + cy + 1) >>> 1;
            // block base must land on the frame, then each cell on its own
            if (on_frame(bx, by))
                for (longint r = 0; r < ky; r++)
                    for (longint k = 0; k < kx; k++)
                        queue_write(bx + k, by + r, color);
        end
        else
        begin
            c  = longint'($signed(settings.cos_q14));
            s  = longint'($signed(settings.sin_q14));
            vx = ox * c - oy * s + cx * 16384 + 16384;
            vy = ox * s + oy * c + cy * 16384 + 16384;
            bx = vx >>> 15;
            by = vy >>> 15;
            if (on_frame(bx, by))
            begin
                queue_write(bx, by, color);
                // off-axis angle: fill holes with up, down, left, right
                if (c != 0 && s != 0)
                begin
                    queue_write(bx, by - 1, color);
                    queue_write(bx, by + 1, color);
                    queue_write(bx - 1, by, color);
                    queue_write(bx + 1, by, color);
                end
            end
        end
        if (pending_writes.size() > first)
            pending_writes[pending_writes.size() - 1].last = 1'b1;
        return pending_writes.size() - first;
    endfunction

    // ------------------------------------------------------------------------
    // Plan building
    // ------------------------------------------------------------------------
    function automatic void add_setting(input logic [2:0] idx, input logic [31:0] value);
        plan_row_t row;
        row = '{kind: ROW_SETTING, reg_idx: idx, value: value, exp_n: -1, default: '0};
        plan.push_back(row);
    endfunction

    function automatic void add_pixel(input logic cmd, input int x, input int y,
                                      input logic [COLOR_W-1:0] color,
                                      input int exp_n = -1,
                                      input int exp_x = 0, input int exp_y = 0);
        plan_row_t row;
        row = '{kind: ROW_PIXEL, cmd: cmd, x: COORD_W'(x), y: COORD_W'(y),
                color: color, exp_n: exp_n, exp_x: COORD_W'(exp_x),
                exp_y: COORD_W'(exp_y), default: '0};
        plan.push_back(row);
    endfunction

    // ------------------------------------------------------------------------
    // Port drivers (all called at a rising edge)
    // ------------------------------------------------------------------------
    // present one pixel, with an occasional gap first, and wait for the transfer
    task automatic offer_pixel(input logic cmd, input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y,
                               input logic [COLOR_W-1:0] color);
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, color, y, x};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // stop offering, let every owed write arrive, then let dropped pixels clear
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // setup phase, access phase, then idle so writes never overlap
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  settings.frame_width  = value[DIM_W-1:0];
            REG_FRAME_HEIGHT: settings.frame_height = value[DIM_W-1:0];
            REG_CENTER_X2:    settings.center_x2    = value[CTR_W-1:0];
            REG_CENTER_Y2:    settings.center_y2    = value[CTR_W-1:0];
            REG_COS_Q14:      settings.cos_q14      = value[TRIG_W-1:0];
            REG_SIN_Q14:      settings.sin_q14      = value[TRIG_W-1:0];
            REG_SCALE_X:      settings.scale_x      = value[SCL_W-1:0];
            REG_SCALE_Y:      settings.scale_y      = value[SCL_W-1:0];
            default:          ;
        endcase
        settings_done++;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Random settings and pixels
    // ------------------------------------------------------------------------
    // mostly full or partial frames, sometimes oversized or empty
    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 3))
            0:       return DIM_W'(MAX_DIM);
            1:       return DIM_W'($urandom_range(1, MAX_DIM));
            2:       return DIM_W'($urandom_range(MAX_DIM + 1, 4095));
            default: return DIM_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // center coordinate that usually sits on the frame
    function automatic logic [CTR_W-1:0] pick_center(input logic [DIM_W-1:0] dim);
        if ($urandom_range(0, 3) == 0)
            return CTR_W'($urandom_range(0, 8191));
        return CTR_W'($urandom_range(0, 2 * int'(frame_limit(dim)) - 1 + (dim == 0)));
    endfunction

    // source coordinate within a few pixels of the center, or anywhere
    function automatic logic [COORD_W-1:0] pick_coord(input logic [CTR_W-1:0] c2);
        int v;
        if ($urandom_range(0, 3) == 0)
            return COORD_W'($urandom_range(0, 2047));
        v = int'(c2 / 2) + int'($urandom_range(0, 64)) - 32;
        if (v < 0)
            v = 0;
        if (v > 2047)
            v = 2047;
        return COORD_W'(v);
    endfunction

    task automatic randomize_settings();
        logic [DIM_W-1:0]  w, h;
        logic [TRIG_W-1:0] c, s;
        w = pick_dim();
        h = pick_dim();
        // right angles, diagonals, and arbitrary (possibly out of range) trig
        case ($urandom_range(0, 6))
            0:       begin c = 16'h4000; s = 16'h0000; end
            1:       begin c = 16'h0000; s = 16'h4000; end
            2:       begin c = 16'hC000; s = 16'h0000; end
            3:       begin c = 16'h0000; s = 16'hC000; end
            4:       begin c = 16'h2D41; s = 16'h2D41; end
            5:       begin c = 16'hD2BF; s = 16'h2D41; end
            default: begin c = 16'($urandom); s = 16'($urandom); end
        endcase
        write_reg(REG_FRAME_WIDTH,  32'(w));
        write_reg(REG_FRAME_HEIGHT, 32'(h));
        write_reg(REG_CENTER_X2,    32'(pick_center(w)));
        write_reg(REG_CENTER_Y2,    32'(pick_center(h)));
        write_reg(REG_COS_Q14,      32'(c));
        write_reg(REG_SIN_Q14,      32'(s));
        write_reg(REG_SCALE_X,      32'($urandom_range(0, 7)));
        write_reg(REG_SCALE_Y,      32'($urandom_range(0, 7)));
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off on request, none at
    // the tail of the run
    // ------------------------------------------------------------------------
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Output check and activity counter for the watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;

        if (rst_n && m_tvalid && m_tready)
        begin
            got_write.dst_x = m_tdata[10:0];
            got_write.dst_y = m_tdata[21:11];
            got_write.color = m_tdata[45:22];
            got_write.last  = m_tlast;
            writes_checked++;
            if (pending_writes.size() == 0)
            begin
                $display("%0t: unexpected write x=%0d y=%0d color=%06h last=%0b", $time,
                         got_write.dst_x, got_write.dst_y, got_write.color,
                         got_write.last);
                mismatches++;
            end
            else
            begin
                want_write = pending_writes.pop_front();
                if (got_write.dst_x !== want_write.dst_x
                    || got_write.dst_y !== want_write.dst_y
                    || got_write.color !== want_write.color
                    || got_write.last  !== want_write.last)
                begin
                    $display("%0t: write mismatch: expected x=%0d y=%0d color=%06h last=%0b",
                             $time, want_write.dst_x, want_write.dst_y,
                             want_write.color, want_write.last);
                    $display("%0t:                 actual   x=%0d y=%0d color=%06h last=%0b",
                             $time, got_write.dst_x, got_write.dst_y,
                             got_write.color, got_write.last);
                    mismatches++;
                end
            end
        end
    end

    // hang detector: no transfer anywhere for too long
    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no transfer for %0d cycles, %0d writes still owed", $time,
                 WATCHDOG_LIMIT, pending_writes.size());
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        bit                 need_drain;
        logic               cmd;
        logic [COORD_W-1:0] x, y;
        logic [COLOR_W-1:0] color;
        pix_write_t         typed;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        need_drain = 1'b0;

        // register values after reset: identity mapping
        settings.frame_width  = DIM_W'(MAX_DIM);
        settings.frame_height = DIM_W'(MAX_DIM);
        settings.center_x2    = '0;
        settings.center_y2    = '0;
        settings.cos_q14      = 16'h4000;
        settings.sin_q14      = 16'h0000;
        settings.scale_x      = SCL_W'(1);
        settings.scale_y      = SCL_W'(1);

        // identity after reset: every pixel lands on itself
        add_pixel(CMD_ROTATE, 0,    0,    24'h000000, 1, 0,    0);
        add_pixel(CMD_ROTATE, 2047, 2047, 24'hFFFFFF, 1, 2047, 2047);
        add_pixel(CMD_SCALE,  0,    2047, 24'h5A5A5A, 1, 0,    2047);
        add_pixel(CMD_SCALE,  2047, 0,    24'hA5A5A5, 1, 2047, 0);
        // one-pixel frame: only the origin survives
        add_setting(REG_FRAME_WIDTH,  32'd1);
        add_setting(REG_FRAME_HEIGHT, 32'd1);
        add_pixel(CMD_SCALE,  0, 0, 24'h123456, 1, 0, 0);
        add_pixel(CMD_SCALE,  1, 0, 24'h654321, 0);
        add_pixel(CMD_ROTATE, 0, 1, 24'h0F0F0F, 0);
        // zero-sized frame drops everything
        add_setting(REG_FRAME_WIDTH,  32'd0);
        add_pixel(CMD_ROTATE, 0, 0, 24'hF0F0F0, 0);
        // oversized frame acts as the largest one
        add_setting(REG_FRAME_WIDTH,  32'd4095);
        add_setting(REG_FRAME_HEIGHT, 32'd4095);
        add_pixel(CMD_ROTATE, 2047, 2047, 24'h800001, 1, 2047, 2047);
        add_pixel(CMD_SCALE,  2047, 1000, 24'h7FFFFE, 1, 2047, 1000);
        // largest blocks: full, clipped at the right edge, base off the frame
        add_setting(REG_SCALE_X,      32'd4);
        add_setting(REG_SCALE_Y,      32'd4);
        add_setting(REG_FRAME_WIDTH,  32'd2046);
        add_pixel(CMD_SCALE, 0,   0,   24'h112233);
        add_pixel(CMD_SCALE, 511, 100, 24'h445566);
        add_pixel(CMD_SCALE, 600, 0,   24'h778899);
        // scale zero and scale above the limit, odd center at the top of range
        add_setting(REG_SCALE_X,      32'd0);
        add_setting(REG_SCALE_Y,      32'd7);
        add_setting(REG_CENTER_X2,    32'd8191);
        add_setting(REG_CENTER_Y2,    32'd1);
        add_setting(REG_FRAME_WIDTH,  32'd2048);
        add_pixel(CMD_SCALE, 2047, 0, 24'hAABBCC);
        add_pixel(CMD_SCALE, 1000, 3, 24'hDDEEFF);
        // quarter turn about the middle: single write, no fill
        add_setting(REG_CENTER_X2,    32'd2048);
        add_setting(REG_CENTER_Y2,    32'd2048);
        add_setting(REG_COS_Q14,      32'h0000);
        add_setting(REG_SIN_Q14,      32'h4000);
        add_pixel(CMD_ROTATE, 1100, 1000, 24'h102030);
        // half turn
        add_setting(REG_COS_Q14,      32'hC000);
        add_setting(REG_SIN_Q14,      32'h0000);
        add_pixel(CMD_ROTATE, 1024, 1030, 24'h405060);
        // 45 degrees: center plus four neighbors, then clipped at the origin
        add_setting(REG_COS_Q14,      32'h2D41);
        add_setting(REG_SIN_Q14,      32'h2D41);
        add_pixel(CMD_ROTATE, 1030, 1020, 24'h708090);
        add_setting(REG_CENTER_X2,    32'd0);
        add_setting(REG_CENTER_Y2,    32'd0);
        add_pixel(CMD_ROTATE, 0, 0, 24'hA0B0C0);
        // trig values beyond +-1.0 are used as given
        add_setting(REG_COS_Q14,      32'h7FFF);
        add_setting(REG_SIN_Q14,      32'h8000);
        add_pixel(CMD_ROTATE, 3, 5, 24'hD0E0F0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_SETTING)
            begin
                if (need_drain)
                    drain_pipeline();
                need_drain = 1'b0;
                write_reg(plan[i].reg_idx, plan[i].value);
            end
            else
            begin
                offer_pixel(plan[i].cmd, plan[i].x, plan[i].y, plan[i].color);
                need_drain = 1'b1;
                directed_pixels++;
                if (plan[i].exp_n < 0)
                    void'(map_source_pixel(plan[i].cmd, plan[i].x, plan[i].y,
                                           plan[i].color));
                else if (plan[i].exp_n > 0)
                begin
                    typed = '{dst_x: plan[i].exp_x, dst_y: plan[i].exp_y,
                              color: plan[i].color, last: 1'b1};
                    pending_writes.push_back(typed);
                end
            end
        end

        // random settings, each followed by a burst of pixels; the last
        // burst runs without idling
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_pipeline();
            quiet_tail = (phase >= RANDOM_PHASES - 1);
            randomize_settings();
            if (phase == 1)
                hold_request = 1'b1;
            repeat (PIXELS_PER_SET)
            begin
                cmd   = 1'($urandom_range(0, 1));
                x     = pick_coord(settings.center_x2);
                y     = pick_coord(settings.center_y2);
                color = COLOR_W'($urandom_range(0, 24'hFFFFFF));
                offer_pixel(cmd, x, y, color);
                random_pixels++;
                random_writes += map_source_pixel(cmd, x, y, color);
            end
        end

        drain_pipeline();

        $display("Covered %0d directed and %0d random source pixels (%0d random writes)",
                 directed_pixels, random_pixels, random_writes);
        $display("over %0d register writes, %0d destination writes checked, %0d mismatches.",
                 settings_done, writes_checked, mismatches);
        if (mismatches == 0 && pending_writes.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
